>>> rtl/jsu_pkg.sv
// shared types and constants for the json string unescaper
// no dependencies; every other file but jsu_ifs imports this package

package jsu_pkg;

  // queue depth between the decoder and the serialiser
  localparam int unsigned JSU_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    RK_DATA   = 2'd0,
    RK_CLOSED = 2'd1,
    RK_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_UNTERMINATED     = 3'd0,
    ERR_CONTROL_CHAR     = 3'd1,
    ERR_UNTERMINATED_ESC = 3'd2,
    ERR_BAD_U            = 3'd3,
    ERR_UNPAIRED_HIGH    = 3'd4,
    ERR_BAD_LOW          = 3'd5,
    ERR_UNPAIRED_LOW     = 3'd6,
    ERR_BAD_ESCAPE       = 3'd7
  } err_t;

  typedef enum logic [2:0] {
    PH_PLAIN   = 3'd0,
    PH_ESC     = 3'd1,
    PH_HEX1    = 3'd2,
    PH_WANT_BS = 3'd3,
    PH_WANT_U  = 3'd4,
    PH_HEX2    = 3'd5
  } phase_t;

  // one run of results caused by one input item, bytes[0] goes out first
  typedef struct packed {
    kind_t           kind;
    err_t            code;
    logic [1:0]      last_idx;
    logic [3:0][7:0] bytes;
  } desc_t;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_LOWER_B   = 8'h62;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [20:0] CP_MAX_1B   = 21'h00007F;
  localparam logic [20:0] CP_MAX_2B   = 21'h0007FF;
  localparam logic [20:0] CP_MAX_3B   = 21'h00FFFF;
  localparam logic [20:0] CP_SUPP_BASE = 21'h010000;

  // top six bits of a high and of a low surrogate
  localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
  localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

endpackage

>>> rtl/jsu_ifs.sv
// channel interfaces of the json string unescaper
// input carries one raw byte or an end marker, output one result item

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       input_end;

  modport source (output valid, output byte_value, output input_end, input ready);
  modport sink   (input valid, input byte_value, input input_end, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] out_byte;
  logic [2:0] error_code;
  logic       last_of_run;

  modport source (output valid, output result_kind, output out_byte,
                  output error_code, output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input out_byte,
                  input error_code, input last_of_run, output ready);
endinterface

>>> rtl/json_string_unescape_utf8_core.sv
// top level of the json string unescaper to utf-8
// depends on jsu_pkg, jsu_ifs, jsu_front, jsu_queue and jsu_back
//
// in_chan takes one byte of a json string body per item (after the opening
// quote), or an end marker when input_end is high. out_chan gives result
// items: a decoded utf-8 byte, a closed marker or an error code. every item
// that gives results gives one to four of them, and the last one carries
// last_of_run; a backslash, an unfinished hex digit or a pair separator gives
// none.
// each result is registered in the descriptor queue and then in the serialiser before it is offered.
// throughput: one item per cycle while each item gives at most one result and
// out_chan stays ready; a \u escape that expands to several utf-8 bytes holds
// the output while they go out, and the descriptor queue absorbs that so input
// keeps flowing until it fills. the output port shows one byte per cycle while
// ready, so the serialiser sets the sustained rate of output bytes.
// a stall on out_chan holds the current result steady; the queue then fills
// and in_chan.ready drops until room returns.
// reset (rst_n low, synchronous) empties the queue and the serialiser and
// puts the decoder back into the plain string body with its hex and
// surrogate registers cleared.

module json_string_unescape_utf8_core #(
  parameter int unsigned QUEUE_DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  jsu_in_if.sink    in_chan,
  jsu_out_if.source out_chan
);
  import jsu_pkg::*;

  // decoder to queue
  logic  push_valid;
  logic  push_ready;
  desc_t push_data;

  // queue to serialiser
  logic  pop_valid;
  logic  pop_ready;
  desc_t pop_data;

  // front end classifies each byte and builds the whole run at once
  jsu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decouples the two halves so a long run does not stall the decoder until the queue fills
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back end hands the run out one item per cycle while out_chan is ready
  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_chan  (out_chan)
  );

endmodule

>>> rtl/jsu_front.sv
// decoder front end: escape state machine, hex gathering, utf-8 encoding
// depends on jsu_pkg and jsu_in_if; pushes one run descriptor per item that gives results

module jsu_front (
  input  logic           clk,
  input  logic           rst_n,
  jsu_in_if.sink         in_chan,
  output logic           push_valid,
  input  logic           push_ready,
  output jsu_pkg::desc_t push_data
);
  import jsu_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [9:0]  hs_r, hs_nxt;

  logic        accept;
  logic [7:0]  c;
  logic        fin;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] acc_shift;
  logic        last_digit;
  logic        is_high;
  logic        is_low;
  logic [20:0] supp_cp;
  logic        esc_ok;
  logic [7:0]  esc_val;
  logic        res_valid;
  desc_t       res;

  function automatic desc_t single(input kind_t k, input err_t e, input logic [7:0] b);
    desc_t r;
    r          = '0;
    r.kind     = k;
    r.code     = e;
    r.bytes[0] = b;
    return r;
  endfunction

  function automatic desc_t utf8_run(input logic [20:0] cp);
    desc_t r;
    r      = '0;
    r.kind = RK_DATA;
    r.code = ERR_UNTERMINATED;
    if (cp <= CP_MAX_1B) begin
      r.bytes[0] = cp[7:0];
      r.last_idx = 2'd0;
    end else if (cp <= CP_MAX_2B) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.last_idx = 2'd1;
    end else if (cp <= CP_MAX_3B) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.last_idx = 2'd2;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.last_idx = 2'd3;
    end
    return r;
  endfunction

  assign c      = in_chan.byte_value;
  assign fin    = in_chan.input_end;
  assign accept = in_chan.valid && in_chan.ready;

  // the queue having room is the only thing that holds the input
  assign in_chan.ready = push_ready;

  // hex digit in either case
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hex_val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hex_val = 4'(c - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    esc_ok  = 1'b1;
    esc_val = 8'h00;
    case (c)
      CH_QUOTE:     esc_val = 8'h22;
      CH_BACKSLASH: esc_val = 8'h5C;
      CH_SLASH:     esc_val = 8'h2F;
      CH_LOWER_B:   esc_val = 8'h08;
      CH_LOWER_F:   esc_val = 8'h0C;
      CH_LOWER_N:   esc_val = 8'h0A;
      CH_LOWER_R:   esc_val = 8'h0D;
      CH_LOWER_T:   esc_val = 8'h09;
      default:      esc_ok  = 1'b0;
    endcase
  end

  assign acc_shift  = {acc_r[11:0], hex_val};
  assign last_digit = (cnt_r == 2'd3);
  assign is_high    = (acc_shift[15:10] == SURR_HIGH_TAG);
  assign is_low     = (acc_shift[15:10] == SURR_LOW_TAG);
  assign supp_cp    = CP_SUPP_BASE + {1'b0, hs_r, acc_shift[9:0]};

  // next state
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    hs_nxt    = hs_r;
    unique case (phase_r)
      PH_ESC: begin
        if (fin) begin
          phase_nxt = PH_PLAIN; acc_nxt = '0; cnt_nxt = '0; hs_nxt = '0;
        end else if (c == CH_LOWER_U) begin
          phase_nxt = PH_HEX1; acc_nxt = '0; cnt_nxt = '0;
        end else if (esc_ok) begin
          phase_nxt = PH_PLAIN;
        end else begin
          phase_nxt = PH_PLAIN; acc_nxt = '0; cnt_nxt = '0; hs_nxt = '0;
        end
      end
      PH_HEX1, PH_HEX2: begin
        if (fin || !hex_ok) begin
          phase_nxt = PH_PLAIN; acc_nxt = '0; cnt_nxt = '0; hs_nxt = '0;
        end else if (!last_digit) begin
          acc_nxt = acc_shift;
          cnt_nxt = cnt_r + 2'd1;
        end else if (phase_r == PH_HEX1 && is_high) begin
          acc_nxt   = acc_shift;
          cnt_nxt   = '0;
          hs_nxt    = acc_shift[9:0];
          phase_nxt = PH_WANT_BS;
        end else begin
          phase_nxt = PH_PLAIN; acc_nxt = '0; cnt_nxt = '0; hs_nxt = '0;
        end
      end
      PH_WANT_BS: begin
        if (fin || c != CH_BACKSLASH) begin
          phase_nxt = PH_PLAIN; acc_nxt = '0; cnt_nxt = '0; hs_nxt = '0;
        end else begin
          phase_nxt = PH_WANT_U;
        end
      end
      PH_WANT_U: begin
        if (fin || c != CH_LOWER_U) begin
          phase_nxt = PH_PLAIN; acc_nxt = '0; cnt_nxt = '0; hs_nxt = '0;
        end else begin
          phase_nxt = PH_HEX2; acc_nxt = '0; cnt_nxt = '0;
        end
      end
      default: begin
        // plain body, also the two unused codes
        if (fin || c == CH_QUOTE || c < CH_SPACE) begin
          phase_nxt = PH_PLAIN; acc_nxt = '0; cnt_nxt = '0; hs_nxt = '0;
        end else if (c == CH_BACKSLASH) begin
          phase_nxt = PH_ESC;
        end else begin
          phase_nxt = PH_PLAIN;
        end
      end
    endcase
  end

  // results of this item
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    unique case (phase_r)
      PH_ESC: begin
        if (fin) begin
          res_valid = 1'b1; res = single(RK_ERROR, ERR_UNTERMINATED_ESC, 8'h00);
        end else if (c == CH_LOWER_U) begin
          res_valid = 1'b0;
        end else if (esc_ok) begin
          res_valid = 1'b1; res = single(RK_DATA, ERR_UNTERMINATED, esc_val);
        end else begin
          res_valid = 1'b1; res = single(RK_ERROR, ERR_BAD_ESCAPE, 8'h00);
        end
      end
      PH_HEX1: begin
        if (fin || !hex_ok) begin
          res_valid = 1'b1; res = single(RK_ERROR, ERR_BAD_U, 8'h00);
        end else if (last_digit && is_low) begin
          res_valid = 1'b1; res = single(RK_ERROR, ERR_UNPAIRED_LOW, 8'h00);
        end else if (last_digit && !is_high) begin
          res_valid = 1'b1; res = utf8_run({5'd0, acc_shift});
        end
      end
      PH_HEX2: begin
        if (fin || !hex_ok || (last_digit && !is_low)) begin
          res_valid = 1'b1; res = single(RK_ERROR, ERR_BAD_LOW, 8'h00);
        end else if (last_digit) begin
          res_valid = 1'b1; res = utf8_run(supp_cp);
        end
      end
      PH_WANT_BS: begin
        if (fin || c != CH_BACKSLASH) begin
          res_valid = 1'b1; res = single(RK_ERROR, ERR_UNPAIRED_HIGH, 8'h00);
        end
      end
      PH_WANT_U: begin
        if (fin || c != CH_LOWER_U) begin
          res_valid = 1'b1; res = single(RK_ERROR, ERR_UNPAIRED_HIGH, 8'h00);
        end
      end
      default: begin
        if (fin) begin
          res_valid = 1'b1; res = single(RK_ERROR, ERR_UNTERMINATED, 8'h00);
        end else if (c == CH_QUOTE) begin
          res_valid = 1'b1; res = single(RK_CLOSED, ERR_UNTERMINATED, 8'h00);
        end else if (c < CH_SPACE) begin
          res_valid = 1'b1; res = single(RK_ERROR, ERR_CONTROL_CHAR, 8'h00);
        end else if (c != CH_BACKSLASH) begin
          res_valid = 1'b1; res = single(RK_DATA, ERR_UNTERMINATED, c);
        end
      end
    endcase
  end

  assign push_valid = accept && res_valid;
  assign push_data  = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLAIN;
      acc_r   <= '0;
      cnt_r   <= '0;
      hs_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      hs_r    <= hs_nxt;
    end
  end

endmodule

>>> rtl/jsu_queue.sv
// short queue of run descriptors between decoder and serialiser
// depends on jsu_pkg; flop storage, depth set by parameter

module jsu_queue #(
  parameter int unsigned DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  jsu_pkg::desc_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output jsu_pkg::desc_t pop_data
);
  import jsu_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  desc_t          mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/jsu_back.sv
// serialiser back end: turns one run descriptor into one to four items
// depends on jsu_pkg and jsu_out_if

module jsu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  jsu_pkg::desc_t pop_data,
  jsu_out_if.source      out_chan
);
  import jsu_pkg::*;

  desc_t      cur_r;
  logic       cur_valid_r;
  logic [1:0] idx_r;
  logic       at_last;
  logic       load;

  assign at_last   = (idx_r == cur_r.last_idx);
  assign load      = !cur_valid_r || (out_chan.ready && at_last);
  assign pop_ready = load;

  assign out_chan.valid       = cur_valid_r;
  assign out_chan.result_kind = cur_r.kind;
  assign out_chan.out_byte    = cur_r.bytes[idx_r];
  assign out_chan.error_code  = cur_r.code;
  assign out_chan.last_of_run = at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      cur_valid_r <= pop_valid;
      idx_r       <= '0;
    end else if (out_chan.ready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && pop_valid) begin
      cur_r <= pop_data;
    end
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for json_string_unescape_utf8_core: json string bodies in, utf-8 out
// depends on jsu_pkg and the jsu_in_if / jsu_out_if channel interfaces

module testbench;
  import jsu_pkg::*;

  localparam int RANDOM_ITEMS = 125;
  localparam int HOLD_CYCLES  = 80;
  // worst case is far below this: every item gives up to 4 results, each
  // behind the longest receiver stall plus the longest sender gap
  localparam int CYCLE_LIMIT  = 200000;

  // one result item as the output channel shows it
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    err_t       code;
    logic       last;
  } utf8_res_t;

  // one input item: a body byte or the end marker
  typedef struct packed {
    logic [7:0] value;
    logic       is_end;
  } body_item_t;

  // -------------------------------------------------------------------------
  // scoreboard: decodes every accepted item on its own and keeps the utf-8
  // results still owed by the block, oldest first
  // -------------------------------------------------------------------------
  class unescape_scoreboard;
    phase_t      cur_phase;
    logic [15:0] hex_acc;
    logic [1:0]  hex_cnt;
    logic [9:0]  high_half;
    utf8_res_t   decoded_q[$];
    int          items_in;
    int          results_seen;
    int          mismatches;
    int          data_seen;
    int          closed_seen;
    int          errors_seen;
    int          four_byte_runs;
    bit [7:0]    codes_seen;

    function new();
      restart();
    endfunction

    function void restart();
      cur_phase = PH_PLAIN;
      hex_acc   = '0;
      hex_cnt   = '0;
      high_half = '0;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    // the code field reads zero on anything but an error
    function utf8_res_t data_item(logic [7:0] v);
      return '{RK_DATA, v, ERR_UNTERMINATED, 1'b0};
    endfunction

    function void note_input(logic [7:0] c, logic is_end);
      utf8_res_t   run[$];
      bit          failed;
      bit          emit;
      err_t        why;
      int          nib;
      logic [20:0] cp;
      failed = 1'b0;
      emit   = 1'b0;
      why    = ERR_UNTERMINATED;
      cp     = '0;
      items_in++;
      case (cur_phase)
        PH_ESC: begin
          if (is_end) begin
            failed = 1'b1;
            why    = ERR_UNTERMINATED_ESC;
          end else begin
            cur_phase = PH_PLAIN;
            case (c)
              CH_QUOTE:     run.push_back(data_item(CH_QUOTE));
              CH_BACKSLASH: run.push_back(data_item(CH_BACKSLASH));
              CH_SLASH:     run.push_back(data_item(CH_SLASH));
              CH_LOWER_B:   run.push_back(data_item(8'h08)); // backspace
              CH_LOWER_F:   run.push_back(data_item(8'h0C)); // form feed
              CH_LOWER_N:   run.push_back(data_item(8'h0A)); // line feed
              CH_LOWER_R:   run.push_back(data_item(8'h0D)); // carriage return
              CH_LOWER_T:   run.push_back(data_item(8'h09)); // tab
              CH_LOWER_U: begin
                cur_phase = PH_HEX1;
                hex_acc   = '0;
                hex_cnt   = '0;
              end
              default: begin
                failed = 1'b1;
                why    = ERR_BAD_ESCAPE;
              end
            endcase
          end
        end
        PH_HEX1, PH_HEX2: begin
          if (c >= "0" && c <= "9") nib = int'(c - "0");
          else if (c >= "a" && c <= "f") nib = int'(c - "a") + 10;
          else if (c >= "A" && c <= "F") nib = int'(c - "A") + 10;
          else nib = -1;
          if (is_end || nib < 0) begin
            failed = 1'b1;
            if (cur_phase == PH_HEX1) why = ERR_BAD_U;
            else why = ERR_BAD_LOW;
          end else begin
            hex_acc = {hex_acc[11:0], nib[3:0]};
            if (hex_cnt != 2'd3) begin
              hex_cnt = hex_cnt + 2'd1;
            end else if (cur_phase == PH_HEX1) begin
              if (hex_acc[15:10] == SURR_HIGH_TAG) begin
                high_half = hex_acc[9:0];
                hex_cnt   = '0;
                cur_phase = PH_WANT_BS;
              end else if (hex_acc[15:10] == SURR_LOW_TAG) begin
                failed = 1'b1;
                why    = ERR_UNPAIRED_LOW;
              end else begin
                emit = 1'b1;
                cp   = {5'd0, hex_acc};
              end
            end else if (hex_acc[15:10] != SURR_LOW_TAG) begin
              failed = 1'b1;
              why    = ERR_BAD_LOW;
            end else begin
              emit = 1'b1;
              cp   = CP_SUPP_BASE + {1'b0, high_half, 10'd0} + {11'd0, hex_acc[9:0]};
            end
          end
        end
        PH_WANT_BS: begin
          if (is_end || c != CH_BACKSLASH) begin
            failed = 1'b1;
            why    = ERR_UNPAIRED_HIGH;
          end else begin
            cur_phase = PH_WANT_U;
          end
        end
        PH_WANT_U: begin
          if (is_end || c != CH_LOWER_U) begin
            failed = 1'b1;
            why    = ERR_UNPAIRED_HIGH;
          end else begin
            cur_phase = PH_HEX2;
            hex_acc   = '0;
            hex_cnt   = '0;
          end
        end
        default: begin
          if (is_end) begin
            failed = 1'b1;
            why    = ERR_UNTERMINATED;
          end else if (c == CH_QUOTE) begin
            restart();
            run.push_back('{RK_CLOSED, 8'h00, ERR_UNTERMINATED, 1'b0});
          end else if (c < CH_SPACE) begin
            failed = 1'b1;
            why    = ERR_CONTROL_CHAR;
          end else if (c == CH_BACKSLASH) begin
            cur_phase = PH_ESC;
          end else begin
            run.push_back(data_item(c));
          end
        end
      endcase
      if (emit) begin
        if (cp <= CP_MAX_1B) begin
          run.push_back(data_item(cp[7:0]));
        end else if (cp <= CP_MAX_2B) begin
          run.push_back(data_item({3'b110, cp[10:6]}));
          run.push_back(data_item({2'b10, cp[5:0]}));
        end else if (cp <= CP_MAX_3B) begin
          run.push_back(data_item({4'b1110, cp[15:12]}));
          run.push_back(data_item({2'b10, cp[11:6]}));
          run.push_back(data_item({2'b10, cp[5:0]}));
        end else begin
          run.push_back(data_item({5'b11110, cp[20:18]}));
          run.push_back(data_item({2'b10, cp[17:12]}));
          run.push_back(data_item({2'b10, cp[11:6]}));
          run.push_back(data_item({2'b10, cp[5:0]}));
          four_byte_runs++;
        end
        restart();
      end
      if (failed) begin
        restart();
        run.push_back('{RK_ERROR, 8'h00, why, 1'b0});
      end
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      foreach (run[i]) decoded_q.push_back(run[i]);
    endfunction

    task report(string what);
      mismatches++;
      $display("[%0t] result %0d: %s", $time, results_seen, what);
    endtask

    task check_result(logic [1:0] kind, logic [7:0] data, logic [2:0] code, logic last);
      utf8_res_t want;
      results_seen++;
      if (decoded_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d byte %h code %0d", kind, data, code));
        return;
      end
      want = decoded_q.pop_front();
      if (kind !== want.kind)
        report($sformatf("result_kind %0d, want %0d", kind, want.kind));
      if (data !== want.data)
        report($sformatf("out_byte %h, want %h", data, want.data));
      if (code !== want.code)
        report($sformatf("error_code %0d, want %0d", code, want.code));
      if (last !== want.last)
        report($sformatf("last_of_run %b, want %b", last, want.last));
      case (want.kind)
        RK_DATA:   data_seen++;
        RK_CLOSED: closed_seen++;
        default: begin
          errors_seen++;
          codes_seen[want.code] = 1'b1;
        end
      endcase
    endtask
  endclass

  // -------------------------------------------------------------------------
  // clock, reset, channels and the block
  // -------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  jsu_in_if  in_chan ();
  jsu_out_if out_chan ();

  json_string_unescape_utf8_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  unescape_scoreboard sb;
  body_item_t         stim_q[$];
  bit                 sender_idle   = 1'b0;
  bit                 receiver_idle = 1'b0;
  int                 receiver_hold = 0;
  int                 items_sent    = 0;
  int                 directed_items;
  int                 cycle_count   = 0;

  // -------------------------------------------------------------------------
  // stimulus building: everything lands in stim_q, send_items drains it
  // -------------------------------------------------------------------------
  function void push_char(logic [7:0] v);
    stim_q.push_back('{v, 1'b0});
  endfunction

  // the byte under an end marker is ignored, so make it random
  function void push_end();
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    stim_q.push_back('{junk, 1'b1});
  endfunction

  function void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endfunction

  // hex digit with letters in either case
  function logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return "0" + v;
    if ($urandom_range(0, 1)) return "a" + v - 8'd10;
    return "A" + v - 8'd10;
  endfunction

  function void push_hex16(logic [15:0] v);
    for (int i = 3; i >= 0; i--) push_char(hex_char(v[4*i +: 4]));
  endfunction

  function logic [7:0] rand_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
    return c;
  endfunction

  // a bmp code point that is not a surrogate, spread over the utf-8 lengths
  function logic [15:0] rand_bmp();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(16'h0000, 16'h007F));
      1:       return 16'($urandom_range(16'h0080, 16'h07FF));
      2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
      default: return 16'($urandom_range(16'hE000, 16'hFFFF));
    endcase
  endfunction

  // one malformed tail; the string ends with the error it causes
  function void push_fault();
    logic [7:0]  c;
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0: push_end();
      1: push_char(8'($urandom_range(0, 31)));
      2: begin
        push_char(CH_BACKSLASH);
        push_end();
      end
      3: begin
        // bad or missing digit inside the first \u escape
        push_text("\\u");
        repeat ($urandom_range(0, 3)) push_char(hex_char(4'($urandom_range(0, 15))));
        if ($urandom_range(0, 1)) push_end();
        else push_char(rand_non_hex());
      end
      4: begin
        // high surrogate with no proper \u after it
        push_text("\\u");
        push_hex16(16'hD800 | 16'($urandom_range(0, 1023)));
        case ($urandom_range(0, 3))
          0: push_end();
          1: begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_BACKSLASH);
            push_char(c);
          end
          2: begin
            push_char(CH_BACKSLASH);
            push_end();
          end
          default: begin
            push_char(CH_BACKSLASH);
            do c = 8'($urandom_range(0, 255)); while (c == CH_LOWER_U);
            push_char(c);
          end
        endcase
      end
      5: begin
        // high surrogate followed by a broken low half
        push_text("\\u");
        push_hex16(16'hD800 | 16'($urandom_range(0, 1023)));
        push_text("\\u");
        case ($urandom_range(0, 2))
          0: begin
            repeat ($urandom_range(0, 3)) push_char(hex_char(4'($urandom_range(0, 15))));
            push_char(rand_non_hex());
          end
          1: begin
            repeat ($urandom_range(0, 3)) push_char(hex_char(4'($urandom_range(0, 15))));
            push_end();
          end
          default: begin
            do v = 16'($urandom_range(0, 16'hFFFF)); while (v[15:10] == SURR_LOW_TAG);
            push_hex16(v);
          end
        endcase
      end
      6: begin
        push_text("\\u");
        push_hex16(16'hDC00 | 16'($urandom_range(0, 1023)));
      end
      default: begin
        // escape letter that json does not know
        push_char(CH_BACKSLASH);
        do c = 8'($urandom_range(0, 255));
        while (c == CH_QUOTE || c == CH_BACKSLASH || c == CH_SLASH || c == CH_LOWER_B ||
               c == CH_LOWER_F || c == CH_LOWER_N || c == CH_LOWER_R ||
               c == CH_LOWER_T || c == CH_LOWER_U);
        push_char(c);
      end
    endcase
  endfunction

  // a well-formed string body with random content, sometimes cut short by a fault
  function void build_string();
    logic [7:0] c;
    int         segs;
    segs = $urandom_range(1, 6);
    for (int s = 0; s < segs; s++) begin
      if ($urandom_range(0, 99) < 6) begin
        push_fault();
        return;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          repeat ($urandom_range(1, 4)) begin
            do c = 8'($urandom_range(8'h20, 8'hFF));
            while (c == CH_QUOTE || c == CH_BACKSLASH);
            push_char(c);
          end
        end
        4, 5: begin
          push_char(CH_BACKSLASH);
          case ($urandom_range(0, 7))
            0:       push_char(CH_QUOTE);
            1:       push_char(CH_BACKSLASH);
            2:       push_char(CH_SLASH);
            3:       push_char(CH_LOWER_B);
            4:       push_char(CH_LOWER_F);
            5:       push_char(CH_LOWER_N);
            6:       push_char(CH_LOWER_R);
            default: push_char(CH_LOWER_T);
          endcase
        end
        6, 7: begin
          push_text("\\u");
          push_hex16(rand_bmp());
        end
        default: begin
          push_text("\\u");
          push_hex16(16'hD800 | 16'($urandom_range(0, 1023)));
          push_text("\\u");
          push_hex16(16'hDC00 | 16'($urandom_range(0, 1023)));
        end
      endcase
    end
    push_char(CH_QUOTE);
  endfunction

  // mostly proper strings, now and then a burst of raw noise
  function void build_batch();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 7) == 0) push_end();
        else push_char(8'($urandom_range(0, 255)));
      end
    end else begin
      build_string();
    end
  endfunction

  // -------------------------------------------------------------------------
  // driving: items go out at the rising edge, acceptance is seen at the next
  // edge where ready was high; valid stays up between back-to-back items
  // -------------------------------------------------------------------------
  task automatic send_items();
    body_item_t it;
    int         gap;
    while (stim_q.size() > 0) begin
      it  = stim_q.pop_front();
      gap = sender_idle ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_chan.valid      <= 1'b1;
      in_chan.byte_value <= it.value;
      in_chan.input_end  <= it.is_end;
      do @(posedge clk); while (in_chan.ready !== 1'b1);
      sb.note_input(it.value, it.is_end);
      items_sent++;
    end
  endtask

  // sender goes quiet until every owed result has come back
  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // receiver: a random stall before each result, or a long hold on request
  initial begin
    int stall;
    forever begin
      if (receiver_hold > 0) begin
        stall         = receiver_hold;
        receiver_hold = 0;
      end else begin
        stall = receiver_idle ? $urandom_range(0, 14) : 0;
      end
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
      sb.check_result(out_chan.result_kind, out_chan.out_byte,
                      out_chan.error_code, out_chan.last_of_run);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results still owed", cycle_count, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    sb                 = new();
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.byte_value = '0;
    in_chan.input_end  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, an escape, \u0000, and the error paths that
    // fit in a short run, each one recovering into a fresh string
    push_text(" ");
    push_char(8'hFF);
    push_text("\\n");
    push_text("\\u0000");
    push_char(8'h1F);            // raw control byte
    push_end();                  // end in plain body
    push_char(CH_BACKSLASH);
    push_end();                  // end right after a backslash
    push_text("\\x");            // unknown escape letter
    push_text("\\ug");           // bad hex digit
    push_text("\\uDC00");        // lone low surrogate
    push_char(CH_QUOTE);         // closing quote
    send_items();
    directed_items = items_sent;
    drain();

    // random strings with both sides idling
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    while (items_sent < directed_items + RANDOM_ITEMS / 3) begin
      build_batch();
      send_items();
    end

    // back-pressure: receiver holds off for a long stretch while the sender
    // keeps offering, so the queue fills and in_chan.ready drops
    sender_idle   = 1'b0;
    receiver_hold = HOLD_CYCLES;
    repeat (4) build_string();
    send_items();
    drain();

    // rest of the random run, idling switched per batch to give quiet stretches
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      sender_idle   = $urandom_range(0, 3) != 0;
      receiver_idle = $urandom_range(0, 3) != 0;
      build_batch();
      send_items();
    end

    drain();
    repeat (8) @(posedge clk);

    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("covered %0d input items (%0d directed) with a %0d cycle output hold",
             sb.items_in, directed_items, HOLD_CYCLES);
    $display("checked %0d results: %0d data, %0d closed, %0d errors (codes %b), %0d 4-byte runs",
             sb.results_seen, sb.data_seen, sb.closed_seen, sb.errors_seen,
             sb.codes_seen, sb.four_byte_runs);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> json_string_unescape_utf8_core.f
rtl/jsu_pkg.sv
rtl/jsu_ifs.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8_core.sv
dv/testbench.sv
